[rtl/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Implication on the next clock edge, switched off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Check that also runs across the release of reset.
`define ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("check across reset failed");

`endif

[rtl/hsl_pkg.sv]
// Types, constants and register codes of the heightmap slope lighting core.
package hsl_pkg;

  localparam int MaxSideDef = 256;
  localparam int QueueDepth = 2;
  localparam int CoordW     = 8;
  localparam int NeighW     = 9;
  localparam int CfgDataW   = 26;
  localparam int CfgIdxW    = 3;
  localparam int ProdW      = 44;
  localparam int SlopeW     = 45;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_DIR_X        = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DIR_Z        = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MIN_LEVEL    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LEVEL    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_INV_SOFTNESS = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MAP_SIDE     = 3'd5;

  // Command codes
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Reset values of the registers
  localparam logic [1:0]  RST_DIR_X        = 2'b01;
  localparam logic [1:0]  RST_DIR_Z        = 2'b01;
  localparam logic [7:0]  RST_MIN_LEVEL    = 8'd89;
  localparam logic [7:0]  RST_MAX_LEVEL    = 8'd255;
  localparam logic [25:0] RST_INV_SOFTNESS = 26'd2048;
  localparam logic [8:0]  RST_MAP_SIDE     = 9'd256;

  // 255 in Q.16
  localparam logic signed [SlopeW-1:0] FULL_SCALE_Q16 = 45'sd16711680;

  typedef struct packed {
    logic [1:0]  dir_x;
    logic [1:0]  dir_z;
    logic [7:0]  min_level;
    logic [7:0]  max_level;
    logic [25:0] inv_softness;
    logic [8:0]  map_side;
  } cfg_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] x_coord;
    logic [7:0] z_coord;
    logic [7:0] height;
  } item_t;

  typedef struct packed {
    logic [7:0] brightness;
    logic       in_range;
  } result_t;

  typedef enum logic [1:0] {
    JOB_STORE,
    JOB_SHADE,
    JOB_EDGE,
    JOB_OUTSIDE
  } job_e;

  typedef struct packed {
    job_e              kind;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] z;
    logic [NeighW-1:0] nx;
    logic [NeighW-1:0] nz;
    logic [7:0]        height;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_NEIGH,
    BK_MULT,
    BK_FINAL
  } back_state_e;

endpackage

[rtl/heightmap_slope_lighting_core.sv]
// Top level of the heightmap slope lighting core.
//
//   channel   direction  handshake                    payload
//   command   in         start_i, transfer if !busy_o item_i (hsl_pkg::item_t)
//   result    out        result_valid_o, one cycle    result_o (hsl_pkg::result_t)
//   config    in         cfg_we_i, no wait            cfg_idx_i, cfg_wdata_i
//
// A store writes memory in the idle state; an edge or off-map read is answered
// there and its result shows on the next cycle. A shading read runs IDLE, NEIGH,
// MULT, FINAL: single-port reads of point, then neighbour, a multiply, a clamp.
// A two-entry job queue sits between classifier and back end; busy_o is high
// while it is full. Reset clears control state only; the height memory holds
// nothing defined until written. Results are strobed and cannot be stalled.
module heightmap_slope_lighting_core #(
  parameter int MAX_SIDE = hsl_pkg::MaxSideDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  hsl_pkg::item_t               item_i,
  output logic                         result_valid_o,
  output hsl_pkg::result_t             result_o,
  input  logic                         cfg_we_i,
  input  logic [hsl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hsl_pkg::CfgDataW-1:0] cfg_wdata_i
);

  hsl_pkg::cfg_t cfg_q, cfg_d;
  hsl_pkg::job_t front_job, head_job;
  logic          accept;
  logic          push;
  logic          pop;
  logic          q_empty, q_full;

  // Register writes; indexes beyond the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hsl_pkg::CFG_DIR_X:        cfg_d.dir_x        = cfg_wdata_i[1:0];
        hsl_pkg::CFG_DIR_Z:        cfg_d.dir_z        = cfg_wdata_i[1:0];
        hsl_pkg::CFG_MIN_LEVEL:    cfg_d.min_level    = cfg_wdata_i[7:0];
        hsl_pkg::CFG_MAX_LEVEL:    cfg_d.max_level    = cfg_wdata_i[7:0];
        hsl_pkg::CFG_INV_SOFTNESS: cfg_d.inv_softness = cfg_wdata_i[25:0];
        hsl_pkg::CFG_MAP_SIDE:     cfg_d.map_side     = cfg_wdata_i[8:0];
        default:                   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dir_x        <= hsl_pkg::RST_DIR_X;
      cfg_q.dir_z        <= hsl_pkg::RST_DIR_Z;
      cfg_q.min_level    <= hsl_pkg::RST_MIN_LEVEL;
      cfg_q.max_level    <= hsl_pkg::RST_MAX_LEVEL;
      cfg_q.inv_softness <= hsl_pkg::RST_INV_SOFTNESS;
      cfg_q.map_side     <= hsl_pkg::RST_MAP_SIDE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Take a command whenever the queue has room
  assign busy_o = q_full;
  assign accept = start_i && !q_full;

  hsl_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .accept_i (accept),
    .item_i   (item_i),
    .cfg_i    (cfg_q),
    .push_o   (push),
    .job_o    (front_job)
  );

  hsl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  hsl_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (head_job),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

endmodule

[rtl/hsl_front.sv]
// Front end: classify an accepted item and form its job for the queue.
module hsl_front #(
  parameter int MAX_SIDE = hsl_pkg::MaxSideDef
) (
  input  logic           accept_i,
  input  hsl_pkg::item_t item_i,
  input  hsl_pkg::cfg_t  cfg_i,
  output logic           push_o,
  output hsl_pkg::job_t  job_o
);

  localparam int LimW  = $clog2(MAX_SIDE + 1);
  localparam int SideW = (LimW > 9) ? LimW : 9;

  logic [SideW-1:0] side;
  logic [SideW-1:0] side_cfg;
  logic [SideW-1:0] x_ext;
  logic [SideW-1:0] z_ext;
  logic             on_map;
  logic             x_pos, x_neg, z_pos, z_neg;
  logic             edge_x, edge_z;

  assign side_cfg = SideW'(cfg_i.map_side);
  assign side     = (side_cfg > SideW'(MAX_SIDE)) ? SideW'(MAX_SIDE) : side_cfg;
  assign x_ext    = SideW'(item_i.x_coord);
  assign z_ext    = SideW'(item_i.z_coord);
  assign on_map   = (x_ext < side) && (z_ext < side);

  // Code 2'b10 saturates to -1; a zero direction acts as (1,1)
  always_comb begin
    x_pos = (cfg_i.dir_x == 2'b01);
    x_neg = cfg_i.dir_x[1];
    z_pos = (cfg_i.dir_z == 2'b01);
    z_neg = cfg_i.dir_z[1];
    if (cfg_i.dir_x == 2'b00 && cfg_i.dir_z == 2'b00) begin
      x_pos = 1'b1;
      z_pos = 1'b1;
    end
  end

  assign edge_x = (x_pos && item_i.x_coord == '0) || (x_neg && (x_ext + 1'b1) >= side);
  assign edge_z = (z_pos && item_i.z_coord == '0) || (z_neg && (z_ext + 1'b1) >= side);

  always_comb begin
    job_o.x      = item_i.x_coord;
    job_o.z      = item_i.z_coord;
    job_o.height = item_i.height;
    job_o.nx     = {1'b0, item_i.x_coord};
    job_o.nz     = {1'b0, item_i.z_coord};
    if (x_pos) job_o.nx = {1'b0, item_i.x_coord} - 9'd1;
    if (x_neg) job_o.nx = {1'b0, item_i.x_coord} + 9'd1;
    if (z_pos) job_o.nz = {1'b0, item_i.z_coord} - 9'd1;
    if (z_neg) job_o.nz = {1'b0, item_i.z_coord} + 9'd1;
    priority if (item_i.cmd == hsl_pkg::CMD_STORE) begin
      job_o.kind = hsl_pkg::JOB_STORE;
    end else if (!on_map) begin
      job_o.kind = hsl_pkg::JOB_OUTSIDE;
    end else if (edge_x || edge_z) begin
      job_o.kind = hsl_pkg::JOB_EDGE;
    end else begin
      job_o.kind = hsl_pkg::JOB_SHADE;
    end
  end

  // Drop stores outside the map here
  assign push_o = accept_i && (on_map || item_i.cmd == hsl_pkg::CMD_READ);

endmodule

[rtl/hsl_queue.sv]
// Short job queue between the front end and the back end.
module hsl_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hsl_pkg::job_t job_i,
  input  logic          pop_i,
  output hsl_pkg::job_t job_o,
  output logic          empty_o,
  output logic          full_o
);

  localparam int Depth = hsl_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  hsl_pkg::job_t   entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    if (do_pop && !do_push) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entries_q[wr_ptr_q] <= job_i;
  end

endmodule

[rtl/hsl_back.sv]
// Back end: height memory, slope arithmetic and result register.
module hsl_back #(
  parameter int MAX_SIDE = hsl_pkg::MaxSideDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hsl_pkg::cfg_t    cfg_i,
  input  hsl_pkg::job_t    job_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             res_valid_o,
  output hsl_pkg::result_t res_o
);

  localparam int Entries = MAX_SIDE * MAX_SIDE;
  localparam int AddrW   = $clog2(Entries);

  hsl_pkg::back_state_e state_q, state_d;
  hsl_pkg::job_t        job_q;

  logic [7:0]       height_mem_q [Entries];
  logic [7:0]       rdata_q;
  logic [7:0]       cur_q;
  logic [AddrW-1:0] addr;
  logic [8:0]       sel_x, sel_z;
  logic             mem_we;
  logic             take;

  logic signed [8:0]               diff;
  logic signed [16:0]              slope;
  logic signed [26:0]              inv_s;
  logic signed [hsl_pkg::ProdW-1:0]  prod_q;
  logic signed [hsl_pkg::SlopeW-1:0] level;
  logic [7:0]                      raw_b, lo, hi, final_b;

  logic             res_valid_q, res_valid_d;
  hsl_pkg::result_t res_q, res_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hsl_pkg::BK_IDLE: begin
        if (!empty_i && job_i.kind == hsl_pkg::JOB_SHADE) state_d = hsl_pkg::BK_NEIGH;
      end
      hsl_pkg::BK_NEIGH: state_d = hsl_pkg::BK_MULT;
      hsl_pkg::BK_MULT:  state_d = hsl_pkg::BK_FINAL;
      hsl_pkg::BK_FINAL: state_d = hsl_pkg::BK_IDLE;
    endcase
  end

  // Levels, swapped when given the wrong way round
  assign lo = (cfg_i.min_level > cfg_i.max_level) ? cfg_i.max_level : cfg_i.min_level;
  assign hi = (cfg_i.min_level > cfg_i.max_level) ? cfg_i.min_level : cfg_i.max_level;

  // Slope: 255*(nb - cur) times 1/softness
  assign diff  = $signed({1'b0, rdata_q}) - $signed({1'b0, cur_q});
  assign slope = $signed({diff, 8'b0}) - 17'(diff);
  assign inv_s = $signed({1'b0, cfg_i.inv_softness});
  assign level = hsl_pkg::FULL_SCALE_Q16 - hsl_pkg::SlopeW'(prod_q);

  always_comb begin
    priority if (level[hsl_pkg::SlopeW-1]) begin
      raw_b = 8'd0;
    end else if (|level[hsl_pkg::SlopeW-2:24]) begin
      raw_b = 8'd255;
    end else begin
      raw_b = level[23:16];
    end
    priority if (raw_b < lo) begin
      final_b = lo;
    end else if (raw_b > hi) begin
      final_b = hi;
    end else begin
      final_b = raw_b;
    end
  end

  // Outputs of the sequencer
  always_comb begin
    take        = 1'b0;
    mem_we      = 1'b0;
    sel_x       = {1'b0, job_i.x};
    sel_z       = {1'b0, job_i.z};
    res_valid_d = 1'b0;
    res_d       = '0;
    unique case (state_q)
      hsl_pkg::BK_IDLE: begin
        take = !empty_i;
        if (!empty_i) begin
          unique case (job_i.kind)
            hsl_pkg::JOB_STORE:   mem_we = 1'b1;
            hsl_pkg::JOB_SHADE:   ;
            hsl_pkg::JOB_EDGE: begin
              res_valid_d = 1'b1;
              res_d       = '{brightness: hi, in_range: 1'b1};
            end
            hsl_pkg::JOB_OUTSIDE: begin
              res_valid_d = 1'b1;
              res_d       = '{brightness: 8'd0, in_range: 1'b0};
            end
          endcase
        end
      end
      hsl_pkg::BK_NEIGH: begin
        sel_x = job_q.nx;
        sel_z = job_q.nz;
      end
      hsl_pkg::BK_MULT: ;
      hsl_pkg::BK_FINAL: begin
        res_valid_d = 1'b1;
        res_d       = '{brightness: final_b, in_range: 1'b1};
      end
    endcase
  end

  assign pop_o = take;
  assign addr  = AddrW'(AddrW'(sel_z) * AddrW'(MAX_SIDE) + AddrW'(sel_x));

  always_ff @(posedge clk_i) begin
    if (mem_we) height_mem_q[addr] <= job_i.height;
    rdata_q <= height_mem_q[addr];
  end

  always_ff @(posedge clk_i) begin
    if (take) job_q <= job_i;
    if (state_q == hsl_pkg::BK_NEIGH) cur_q <= rdata_q;
    if (state_q == hsl_pkg::BK_MULT) begin
      prod_q <= hsl_pkg::ProdW'(slope) * hsl_pkg::ProdW'(inv_s);
    end
    if (res_valid_d) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hsl_pkg::BK_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[rtl/hsl_checker.sv]
// Port-level checker of the lighting core and its bind.
`include "assert_macros.svh"

module hsl_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic                         result_valid_o,
  input hsl_pkg::result_t             result_o,
  input logic                         cfg_we_i,
  input logic [hsl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input logic [hsl_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic [7:0] min_q, max_q;
  logic [7:0] lo, hi;

  // Shadow the level registers from the write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= hsl_pkg::RST_MIN_LEVEL;
      max_q <= hsl_pkg::RST_MAX_LEVEL;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == hsl_pkg::CFG_MIN_LEVEL) min_q <= cfg_wdata_i[7:0];
      if (cfg_idx_i == hsl_pkg::CFG_MAX_LEVEL) max_q <= cfg_wdata_i[7:0];
    end
  end

  assign lo = (min_q > max_q) ? max_q : min_q;
  assign hi = (min_q > max_q) ? min_q : max_q;

  `ASSERT_IMP(off_map_dark, clk_i, rst_ni,
    result_valid_o && !result_o.in_range, result_o.brightness == 8'd0)
  `ASSERT_IMP(level_window, clk_i, rst_ni,
    result_valid_o && result_o.in_range,
    result_o.brightness >= lo && result_o.brightness <= hi)
  `ASSERT_ALWAYS(ready_after_reset, clk_i, $rose(rst_ni), !busy_o)
  `ASSERT_NEXT(idle_keeps_room, clk_i, rst_ni, !busy_o && !start_i, !busy_o)

endmodule

bind heightmap_slope_lighting_core hsl_checker u_hsl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o),
  .cfg_we_i       (cfg_we_i),
  .cfg_idx_i      (cfg_idx_i),
  .cfg_wdata_i    (cfg_wdata_i)
);
